FILE: rtl/tag_access_controller_assert.svh
// assertion macros used by the rtl controller (tac_controller)
`ifndef TAG_ACCESS_CONTROLLER_ASSERT_SVH
`define TAG_ACCESS_CONTROLLER_ASSERT_SVH

`ifndef SYNTHESIS

`define TAC_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tac check failed: implication");

`define TAC_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tac check failed: next cycle");

`else

`define TAC_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define TAC_ASSERT_NXT(name, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/tac_pkg.sv
`timescale 1ns / 1ps
package tac_pkg;

  localparam int LIST_DEPTH = 128;
  localparam int IDX_W = $clog2(LIST_DEPTH);
  localparam int CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int ADDR_W = 5;

  localparam logic [7:0] PULSE_DIVIDE_RST = 8'd16;
  localparam logic [5:0] REMOVE_HOLD_RST = 6'd5;
  localparam logic [5:0] CLEAR_HOLD_RST = 6'd10;
  localparam logic [5:0] FULL_RESET_HOLD_RST = 6'd13;
  localparam logic [5:0] KEYING_TIMEOUT_RST = 6'd10;
  localparam logic [5:0] SEC_MAX = 6'd63;

  typedef enum logic [2:0] {
    REG_PULSE_DIVIDE    = 3'd0,
    REG_REMOVE_HOLD     = 3'd1,
    REG_CLEAR_HOLD      = 3'd2,
    REG_FULL_RESET_HOLD = 3'd3,
    REG_KEYING_TIMEOUT  = 3'd4
  } reg_idx_t;

  typedef enum logic [3:0] {
    EV_NONE       = 4'd0,
    EV_GRANT      = 4'd1,
    EV_DENY       = 4'd2,
    EV_FOREIGN    = 4'd3,
    EV_MASTER_SET = 4'd4,
    EV_ACK        = 4'd5,
    EV_END        = 4'd6,
    EV_REMOVED    = 4'd7,
    EV_CLEARED    = 4'd8,
    EV_FULL_RESET = 4'd9,
    EV_ADDED      = 4'd10,
    EV_FULL       = 4'd11
  } event_t;

  typedef enum logic [1:0] {
    MODE_NOMASTER = 2'd0,
    MODE_IDLE     = 2'd1,
    MODE_KEYING   = 2'd2
  } mode_t;

  typedef struct packed {
    logic        tag_present;
    logic        tag_is_master;
    logic [31:0] tag_uid;
  } in_item_t;

  typedef struct packed {
    logic [3:0] event_res;
    logic [1:0] mode;
    logic [7:0] member_total;
  } out_item_t;

  typedef struct packed {
    logic [7:0] pulse_divide;
    logic [5:0] remove_hold;
    logic [5:0] clear_hold;
    logic [5:0] full_reset_hold;
    logic [5:0] keying_timeout;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
    logic shift;
  } tac_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic remove;
    logic shift_done;
    logic out_free;
  } tac_sts_t;

endpackage

FILE: rtl/tac_datapath.sv
`timescale 1ns / 1ps
module tac_datapath
  import tac_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  in_item_t  in_data,
  input  tac_cmd_t  cmd,
  output tac_sts_t  sts,
  output out_item_t out_data,
  output logic      out_valid,
  input  logic      out_ready
);

  logic [31:0] mem [LIST_DEPTH];
  logic [31:0] rdata_r;
  logic [IDX_W-1:0] rd_addr;
  logic        wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [31:0] wr_data;

  in_item_t    in_r;
  logic [31:0] key_r;
  logic [CNT_W-1:0] count_r;
  logic [31:0] master_r;
  mode_t       mode_r;
  logic        prev_r;
  logic [31:0] held_r;
  logic        mseen_r;
  logic [5:0]  hold_r;
  logic [5:0]  absent_r;
  logic        kop_r;
  logic        cdone_r;
  logic        rpend_r;
  logic [7:0]  pc_r;
  logic        sp_r;

  // lookup pipeline
  logic [CNT_W-1:0] issue_r;
  logic        pend_r;
  logic [IDX_W-1:0] pidx_r;
  logic        found_r;
  logic [IDX_W-1:0] fidx_r;
  logic        hit;
  logic        scan_issue;

  // compaction pipeline
  logic [CNT_W-1:0] sh_rd_r;
  logic [IDX_W-1:0] sh_wr_r;
  logic        sh_pend_r;
  logic        sh_issue;

  out_item_t   out_data_r;
  logic        out_valid_r;

  // poll evaluation
  logic        act, ism, epos, eneg;
  logic [31:0] held_nxt, master_nxt;
  logic        mseen_nxt, kop_nxt, cdone_nxt, rpend_nxt, sp_nxt, run_idle;
  mode_t       mode_nxt;
  logic [5:0]  hold_nxt, absent_nxt;
  logic [7:0]  pc_nxt;
  event_t      ev;
  logic        do_clear, do_remove, do_add;
  logic [CNT_W-1:0] cnt_nxt;

  always_comb begin
    act = in_r.tag_present;
    ism = act & in_r.tag_is_master;
    epos = act & ~prev_r;
    eneg = ~act & prev_r;
    held_nxt = epos ? in_r.tag_uid : held_r;
    mseen_nxt = mseen_r | ism;
    mode_nxt = mode_r;
    hold_nxt = hold_r;
    absent_nxt = absent_r;
    kop_nxt = kop_r;
    cdone_nxt = cdone_r;
    rpend_nxt = rpend_r;
    master_nxt = master_r;
    pc_nxt = pc_r;
    ev = EV_NONE;
    do_clear = 1'b0;
    do_remove = 1'b0;
    do_add = 1'b0;
    run_idle = 1'b0;
    sp_nxt = 1'b0;
    if (mode_r != MODE_KEYING) begin
      hold_nxt = '0;
      absent_nxt = '0;
      kop_nxt = 1'b0;
    end
    case (mode_r)
      MODE_NOMASTER: begin
        if (rpend_r) begin
          if (eneg) rpend_nxt = 1'b0;
          if (epos) run_idle = 1'b1;
        end else if (ism) begin
          master_nxt = held_nxt;
          kop_nxt = 1'b1;
          mode_nxt = MODE_KEYING;
          ev = EV_MASTER_SET;
        end
      end
      MODE_IDLE: begin
        if (epos) run_idle = 1'b1;
      end
      MODE_KEYING: begin
        // another master tag ends keying at once
        if (epos && ism && held_nxt != master_r) begin
          ev = EV_END;
          absent_nxt = '0;
          hold_nxt = '0;
          mode_nxt = MODE_IDLE;
        end
        if (act) begin
          absent_nxt = '0;
          if (sp_r && hold_nxt < SEC_MAX) hold_nxt = hold_nxt + 6'd1;
          if (hold_nxt == cfg.remove_hold && !ism && found_r) begin
            do_remove = 1'b1;
            ev = EV_REMOVED;
          end
          if (ism) begin
            if (hold_nxt == cfg.clear_hold && !cdone_nxt) begin
              cdone_nxt = 1'b1;
              do_clear = 1'b1;
              ev = EV_CLEARED;
            end
            if (hold_nxt == cfg.full_reset_hold && !rpend_nxt) begin
              rpend_nxt = 1'b1;
              do_clear = 1'b1;
              master_nxt = '0;
              mode_nxt = MODE_NOMASTER;
              ev = EV_FULL_RESET;
            end
          end
        end else if (sp_r) begin
          if (absent_nxt < SEC_MAX) absent_nxt = absent_nxt + 6'd1;
          if (absent_nxt >= cfg.keying_timeout) begin
            absent_nxt = '0;
            mode_nxt = MODE_IDLE;
            ev = EV_END;
          end
        end
        if (eneg && !rpend_nxt) begin
          cdone_nxt = 1'b0;
          if (mseen_nxt) begin
            if (hold_nxt < cfg.clear_hold) begin
              if (kop_nxt) begin
                ev = EV_ACK;
              end else begin
                ev = EV_END;
                mode_nxt = MODE_IDLE;
              end
            end
          end else if (hold_nxt < cfg.remove_hold) begin
            if (count_r < CNT_W'(LIST_DEPTH)) begin
              do_add = (held_nxt != '0) && !found_r;
              ev = EV_ADDED;
            end else begin
              ev = EV_FULL;
            end
          end
          absent_nxt = '0;
          kop_nxt = 1'b0;
          hold_nxt = '0;
          pc_nxt = '0;
        end
      end
      default: ;
    endcase
    if (run_idle) begin
      if (ism) begin
        if (held_nxt == master_nxt) begin
          kop_nxt = 1'b1;
          mode_nxt = MODE_KEYING;
        end else begin
          ev = EV_FOREIGN;
        end
      end else if (found_r) begin
        ev = EV_GRANT;
      end else if (held_nxt != '0) begin
        ev = EV_DENY;
      end
    end
    if (eneg) begin
      mseen_nxt = 1'b0;
      held_nxt = '0;
    end
    if (pc_nxt >= cfg.pulse_divide) begin
      pc_nxt = '0;
      sp_nxt = 1'b1;
    end else begin
      pc_nxt = pc_nxt + 8'd1;
    end
    if (do_clear) cnt_nxt = '0;
    else if (do_add) cnt_nxt = count_r + CNT_W'(1);
    else if (do_remove) cnt_nxt = count_r - CNT_W'(1);
    else cnt_nxt = count_r;
  end

  assign hit = pend_r && (rdata_r == key_r);
  assign scan_issue = cmd.scan && !hit && (issue_r < count_r);
  assign sh_issue = cmd.shift && (sh_rd_r <= count_r);
  assign rd_addr = sh_issue ? sh_rd_r[IDX_W-1:0] : issue_r[IDX_W-1:0];

  assign wr_en = (cmd.commit && do_add) || (cmd.shift && sh_pend_r);
  assign wr_addr = cmd.shift ? sh_wr_r : count_r[IDX_W-1:0];
  assign wr_data = cmd.shift ? rdata_r : held_r;

  always_ff @(posedge clk) begin
    rdata_r <= mem[rd_addr];
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      master_r <= '0;
      mode_r <= MODE_NOMASTER;
      prev_r <= 1'b0;
      held_r <= '0;
      mseen_r <= 1'b0;
      hold_r <= '0;
      absent_r <= '0;
      kop_r <= 1'b0;
      cdone_r <= 1'b0;
      rpend_r <= 1'b0;
      pc_r <= '0;
      sp_r <= 1'b0;
      pend_r <= 1'b0;
      sh_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) pend_r <= 1'b0;
      else if (cmd.scan) pend_r <= scan_issue;
      sh_pend_r <= sh_issue;
      if (cmd.commit) begin
        count_r <= cnt_nxt;
        master_r <= master_nxt;
        mode_r <= mode_nxt;
        prev_r <= act;
        held_r <= held_nxt;
        mseen_r <= mseen_nxt;
        hold_r <= hold_nxt;
        absent_r <= absent_nxt;
        kop_r <= kop_nxt;
        cdone_r <= cdone_nxt;
        rpend_r <= rpend_nxt;
        pc_r <= pc_nxt;
        sp_r <= sp_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_r <= in_data;
      key_r <= (in_data.tag_present && !prev_r) ? in_data.tag_uid : held_r;
      issue_r <= '0;
      found_r <= 1'b0;
    end
    if (scan_issue) begin
      issue_r <= issue_r + CNT_W'(1);
      pidx_r <= issue_r[IDX_W-1:0];
    end
    if (cmd.scan && hit) begin
      found_r <= 1'b1;
      fidx_r <= pidx_r;
    end
    if (cmd.commit) begin
      sh_rd_r <= CNT_W'(fidx_r) + CNT_W'(1);
      out_data_r.event_res <= ev;
      out_data_r.mode <= mode_nxt;
      out_data_r.member_total <= 8'(cnt_nxt);
    end
    if (sh_issue) begin
      sh_rd_r <= sh_rd_r + CNT_W'(1);
      sh_wr_r <= IDX_W'(sh_rd_r - CNT_W'(1));
    end
  end

  assign sts.scan_done = hit || (!pend_r && !(issue_r < count_r));
  assign sts.remove = do_remove;
  assign sts.shift_done = !sh_pend_r && !(sh_rd_r <= count_r);
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_data = out_data_r;
  assign out_valid = out_valid_r;

endmodule

FILE: rtl/tac_controller.sv
`timescale 1ns / 1ps
`include "tag_access_controller_assert.svh"
module tac_controller
  import tac_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  tac_sts_t sts,
  output tac_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_EVAL  = 4'b0100,
    ST_SHIFT = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        // commit only once the output register can take the result
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt = sts.remove ? ST_SHIFT : ST_IDLE;
        end
      end
      ST_SHIFT: begin
        cmd.shift = 1'b1;
        if (sts.shift_done) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  `TAC_ASSERT_NXT(a_load_scan, clk, rst_n, cmd.load, state_r == ST_SCAN)
  `TAC_ASSERT_IMP(a_commit_free, clk, rst_n, cmd.commit, sts.out_free)
  `TAC_ASSERT_NXT(a_remove_shift, clk, rst_n, cmd.commit && sts.remove, state_r == ST_SHIFT)

endmodule

FILE: rtl/tag_access_controller.sv
`timescale 1ns / 1ps
// tag access controller: one transfer on the input channel is one reader poll
// (presence, master flag, uid); each poll yields exactly one result transfer
// carrying the event code, the mode after the poll and the allow-list count.
// configuration sits on an apb-style port, registers at byte addresses 0..16;
// write them only while no poll is in flight (the block itself does not enforce this).
// each poll passes a load step, a lookup that reads the list entries in order and
// stops on a hit or at member_total, an evaluation step, and after a removal a
// compaction that moves every entry behind the removed one down by one; a removal
// needs a hit, so its lookup has already ended early.
// the list memory has one read and one write port, which sets both the lookup
// and the compaction at one entry per cycle.
// one poll is in flight at a time; the result sits in an output register so
// the next poll is taken while it waits. if the receiver stalls, a finished
// poll holds in evaluation until the output register frees up.
// reset clears the list count, master, mode and counters and loads register
// defaults; the list memory needs no clearing pass since the count bounds it.
module tag_access_controller
  import tac_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t     cfg_r;
  tac_cmd_t cmd;
  tac_sts_t sts;
  reg_idx_t reg_sel;

  assign reg_sel = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pulse_divide <= PULSE_DIVIDE_RST;
      cfg_r.remove_hold <= REMOVE_HOLD_RST;
      cfg_r.clear_hold <= CLEAR_HOLD_RST;
      cfg_r.full_reset_hold <= FULL_RESET_HOLD_RST;
      cfg_r.keying_timeout <= KEYING_TIMEOUT_RST;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        REG_PULSE_DIVIDE:    cfg_r.pulse_divide <= pwdata[7:0];
        REG_REMOVE_HOLD:     cfg_r.remove_hold <= pwdata[5:0];
        REG_CLEAR_HOLD:      cfg_r.clear_hold <= pwdata[5:0];
        REG_FULL_RESET_HOLD: cfg_r.full_reset_hold <= pwdata[5:0];
        REG_KEYING_TIMEOUT:  cfg_r.keying_timeout <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_PULSE_DIVIDE:    prdata = {24'd0, cfg_r.pulse_divide};
      REG_REMOVE_HOLD:     prdata = {26'd0, cfg_r.remove_hold};
      REG_CLEAR_HOLD:      prdata = {26'd0, cfg_r.clear_hold};
      REG_FULL_RESET_HOLD: prdata = {26'd0, cfg_r.full_reset_hold};
      REG_KEYING_TIMEOUT:  prdata = {26'd0, cfg_r.keying_timeout};
      default:             prdata = '0;
    endcase
  end

  tac_controller u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tac_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

endmodule

FILE: test/tag_access_controller_checker.sv
`timescale 1ns / 1ps
module tag_access_controller_checker
  import tac_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  in_item_t          in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  out_item_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  output int                errors,
  output int                pending
);

  // shadow copy of the registers and of the controller state
  logic [7:0]  div_r;
  logic [5:0]  rmv_r, clr_r, frst_r, kto_r;
  logic [31:0] members [LIST_DEPTH];
  int          n_members;
  logic [31:0] master_uid, held, released;
  mode_t       ctl_mode;
  logic        was_present, master_flag, opened, cleared, full_rst_wait, pulse;
  logic [5:0]  held_secs, away_secs;
  logic [7:0]  polls;

  out_item_t   expected_results [$];

  function automatic logic is_member(logic [31:0] uid);
    for (int i = 0; i < n_members && i < LIST_DEPTH; i++) begin
      if (members[i] == 32'd0) return 1'b0;
      if (members[i] == uid) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void drop_member(logic [31:0] uid);
    for (int i = 0; i < n_members && i < LIST_DEPTH; i++) begin
      if (members[i] == uid) begin
        for (int j = i; j + 1 < n_members && j + 1 < LIST_DEPTH; j++)
          members[j] = members[j + 1];
        members[n_members - 1] = 32'd0;
        n_members--;
        return;
      end
    end
  endfunction

  function automatic void wipe_members();
    for (int i = 0; i < LIST_DEPTH; i++) members[i] = 32'd0;
    n_members = 0;
  endfunction

  function automatic event_t edge_in_idle(logic master_tag);
    if (master_tag) begin
      if (held == master_uid) begin
        opened = 1'b1;
        ctl_mode = MODE_KEYING;
        return EV_NONE;
      end
      return EV_FOREIGN;
    end
    if (is_member(held)) return EV_GRANT;
    return (held != 32'd0) ? EV_DENY : EV_NONE;
  endfunction

  function automatic out_item_t poll_outcome(in_item_t p);
    logic      act, mst, rise, fall;
    event_t    ev;
    out_item_t r;
    act  = p.tag_present;
    mst  = act && p.tag_is_master;
    rise = act && !was_present;
    fall = !act && was_present;
    released = 32'd0;
    ev = EV_NONE;
    if (rise) held = p.tag_uid;
    if (mst) master_flag = 1'b1;
    if (fall) released = held;
    if (ctl_mode != MODE_KEYING) begin
      held_secs = '0;
      away_secs = '0;
      opened = 1'b0;
    end
    case (ctl_mode)
      MODE_NOMASTER: begin
        if (full_rst_wait) begin
          if (fall) full_rst_wait = 1'b0;
          if (rise) ev = edge_in_idle(mst);
        end else if (act && mst) begin
          master_uid = held;
          opened = 1'b1;
          ctl_mode = MODE_KEYING;
          ev = EV_MASTER_SET;
        end
      end
      MODE_IDLE: begin
        if (rise) ev = edge_in_idle(mst);
      end
      MODE_KEYING: begin
        if (rise && mst && held != master_uid) begin
          ev = EV_END;
          away_secs = '0;
          held_secs = '0;
          ctl_mode = MODE_IDLE;
        end
        if (act) begin
          away_secs = '0;
          if (pulse && held_secs < SEC_MAX) held_secs++;
          if (held_secs == rmv_r && !mst && is_member(held)) begin
            drop_member(held);
            ev = EV_REMOVED;
          end
          if (mst) begin
            if (held_secs == clr_r && !cleared) begin
              cleared = 1'b1;
              wipe_members();
              ev = EV_CLEARED;
            end
            if (held_secs == frst_r && !full_rst_wait) begin
              full_rst_wait = 1'b1;
              wipe_members();
              master_uid = 32'd0;
              ctl_mode = MODE_NOMASTER;
              ev = EV_FULL_RESET;
            end
          end
        end else if (pulse) begin
          if (away_secs < SEC_MAX) away_secs++;
          if (away_secs >= kto_r) begin
            away_secs = '0;
            ctl_mode = MODE_IDLE;
            ev = EV_END;
          end
        end
        if (fall && !full_rst_wait) begin
          cleared = 1'b0;
          if (master_flag) begin
            if (held_secs < clr_r) begin
              if (opened) ev = EV_ACK;
              else begin
                ev = EV_END;
                ctl_mode = MODE_IDLE;
              end
            end
          end else if (held_secs < rmv_r) begin
            if (n_members < LIST_DEPTH) begin
              if (released != 32'd0 && !is_member(released)) begin
                members[n_members] = released;
                n_members++;
              end
              ev = EV_ADDED;
            end else begin
              ev = EV_FULL;
            end
          end
          away_secs = '0;
          opened = 1'b0;
          held_secs = '0;
          polls = '0;
        end
      end
      default: ;
    endcase
    was_present = act;
    if (fall) begin
      master_flag = 1'b0;
      held = 32'd0;
    end
    pulse = 1'b0;
    if (polls >= div_r) begin
      polls = '0;
      pulse = 1'b1;
    end else begin
      polls = polls + 8'd1;
    end
    r.event_res = ev;
    r.mode = ctl_mode;
    r.member_total = n_members[7:0];
    return r;
  endfunction

  assign pending = expected_results.size();

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      div_r <= PULSE_DIVIDE_RST;
      rmv_r <= REMOVE_HOLD_RST;
      clr_r <= CLEAR_HOLD_RST;
      frst_r <= FULL_RESET_HOLD_RST;
      kto_r <= KEYING_TIMEOUT_RST;
      wipe_members();
      master_uid = '0;
      held = '0;
      ctl_mode = MODE_NOMASTER;
      was_present = 0;
      master_flag = 0;
      opened = 0;
      cleared = 0;
      full_rst_wait = 0;
      pulse = 0;
      held_secs = '0;
      away_secs = '0;
      polls = '0;
      expected_results.delete();
      errors <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_PULSE_DIVIDE:    div_r <= pwdata[7:0];
          REG_REMOVE_HOLD:     rmv_r <= pwdata[5:0];
          REG_CLEAR_HOLD:      clr_r <= pwdata[5:0];
          REG_FULL_RESET_HOLD: frst_r <= pwdata[5:0];
          REG_KEYING_TIMEOUT:  kto_r <= pwdata[5:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          if (errors < 10) $display("unexpected result transfer %p", out_data);
          errors <= errors + 1;
        end else begin
          want = expected_results.pop_front();
          if (out_data.event_res !== want.event_res || out_data.mode !== want.mode ||
              out_data.member_total !== want.member_total) begin
            if (errors < 10)
              $display("mismatch: event %0d/%0d mode %0d/%0d total %0d/%0d (exp/got)",
                       want.event_res, out_data.event_res, want.mode, out_data.mode,
                       want.member_total, out_data.member_total);
            errors <= errors + 1;
          end
        end
      end
      if (in_valid && in_ready) expected_results.push_back(poll_outcome(in_data));
    end
  end

endmodule

FILE: test/tag_access_controller_test.sv
`timescale 1ns / 1ps
module tag_access_controller_test;
  import tac_pkg::*;

  logic              clk = 0;
  logic              rst_n = 0;
  logic              in_valid = 0;
  logic              in_ready;
  in_item_t          in_data = '0;
  logic              out_valid;
  logic              out_ready = 0;
  out_item_t         out_data;
  logic              psel = 0, penable = 0, pwrite = 0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  int                errors, pending;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  tag_access_controller u_top (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  tag_access_controller_checker u_chk (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready, .errors, .pending
  );

  // receiver: alternates stretches of always-ready with stretches of random stalls
  int stall_left = 0;
  logic stall_mode = 0;
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= ($urandom_range(0, 2) == 0);
      stall_left <= $urandom_range(5, 80);
    end else begin
      stall_left <= stall_left - 1;
    end
    out_ready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
  end

  int          burst_left = 0;
  int          polls_sent = 0;
  logic [7:0]  div_c;
  logic [5:0]  rmv_c, clr_c, frst_c, kto_c;
  logic [31:0] master_a, master_b;
  logic [31:0] crew [8];

  task automatic send_poll(logic present, logic master_tag, logic [31:0] uid);
    in_item_t p;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      if ($urandom_range(0, 1)) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
    burst_left--;
    p.tag_present = present;
    p.tag_is_master = master_tag;
    p.tag_uid = uid;
    in_valid <= 1'b1;
    in_data <= p;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    polls_sent++;
  endtask

  // a tag is shown for some polls, then the field stays empty for some polls
  task automatic visit(logic [31:0] uid, logic master_tag, int on_polls, int off_polls);
    for (int i = 0; i < on_polls; i++)
      send_poll(1'b1, master_tag, (i > 0 && $urandom_range(0, 3) == 0) ? $urandom() : uid);
    for (int i = 0; i < off_polls; i++)
      send_poll(1'b0, 1'($urandom_range(0, 1)), $urandom());
  endtask

  task automatic wait_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic reg_write(logic [ADDR_W-1:0] addr, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic load_setting(logic [7:0] d, logic [5:0] r, logic [5:0] c, logic [5:0] f,
                              logic [5:0] k);
    wait_quiet();
    div_c = d; rmv_c = r; clr_c = c; frst_c = f; kto_c = k;
    reg_write(ADDR_W'(4 * int'(REG_PULSE_DIVIDE)),
              {$urandom_range(0, 1) ? 24'($urandom()) : 24'd0, d});
    reg_write(ADDR_W'(4 * int'(REG_REMOVE_HOLD)), {26'd0, r});
    reg_write(ADDR_W'(4 * int'(REG_CLEAR_HOLD)), {26'd0, c});
    reg_write(ADDR_W'(4 * int'(REG_FULL_RESET_HOLD)), {26'd0, f});
    reg_write(ADDR_W'(4 * int'(REG_KEYING_TIMEOUT)), {26'd0, k});
  endtask

  function automatic int clip(int v, int hi);
    return (v > hi) ? hi : v;
  endfunction

  task automatic random_phase(int n);
    int stop, pick, secs, on_p, off_p;
    logic [31:0] m;
    stop = polls_sent + n;
    while (polls_sent < stop) begin
      pick = $urandom_range(0, 99);
      m = ($urandom_range(0, 4) == 0) ? master_b : master_a;
      case ($urandom_range(0, 2))
        0: secs = rmv_c;
        1: secs = clr_c;
        default: secs = frst_c;
      endcase
      on_p = $urandom_range(1, 4);
      if (pick >= 35 && pick < 50 || pick >= 65 && pick < 75)
        on_p = clip(secs * (div_c + 1) + $urandom_range(0, 3), 150);
      off_p = ($urandom_range(0, 9) == 0) ?
              clip(kto_c * (div_c + 1) + 2, 200) : $urandom_range(1, 3);
      if (pick < 50)
        visit(crew[3'($urandom_range(0, 7))], 1'b0, on_p, off_p);
      else if (pick < 75)
        visit(m, 1'b1, on_p, off_p);
      else if (pick < 82)
        visit($urandom(), 1'b1, on_p, off_p);
      else if (pick < 90)
        visit($urandom_range(0, 3) == 0 ? 32'd0 : $urandom(), 1'b0, on_p, off_p);
      else
        visit(32'd0, 1'b0, 0, $urandom_range(1, 5));
    end
  endtask

  initial begin
    div_c = PULSE_DIVIDE_RST; rmv_c = REMOVE_HOLD_RST; clr_c = CLEAR_HOLD_RST;
    frst_c = FULL_RESET_HOLD_RST; kto_c = KEYING_TIMEOUT_RST;
    master_a = $urandom() | 32'h1;
    master_b = $urandom() | 32'h2;
    foreach (crew[i]) crew[i] = $urandom() | 32'h100;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: master setup, keying ack, add, foreign master, grant, deny, zero uid
    visit(32'd0, 1'b0, 1, 1);
    visit(master_a, 1'b1, 2, 1);
    visit(32'hFFFF_FFFF, 1'b0, 1, 1);
    visit(crew[0], 1'b0, 1, 1);
    visit(32'd0, 1'b0, 1, 1);
    visit(master_b, 1'b1, 1, 1);
    visit(crew[0], 1'b0, 1, 1);
    visit(32'h0000_0001, 1'b0, 1, 1);
    visit(32'hFFFF_FFFF, 1'b0, 1, 1);
    visit(master_b, 1'b1, 1, 1);
    visit(master_a, 1'b1, 1, 1);
    visit(32'h8000_0000, 1'b0, 1, 1);

    // largest holds and timeout; master_a ends the open keying, then more tags than the list depth are shown
    load_setting(8'd255, 6'd63, 6'd63, 6'd63, 6'd63);
    reg_write(ADDR_W'(4 * (int'(REG_KEYING_TIMEOUT) + 1)), 32'hFFFF_FFFF);
    visit(master_a, 1'b1, 1, 1);
    for (int i = 0; i < LIST_DEPTH + 3; i++) visit($urandom() | 32'h1, 1'b0, 1, 1);
    visit(master_b, 1'b1, 1, 1);
    random_phase(20);

    load_setting(8'd1, 6'd2, 6'd3, 6'd4, 6'd3);
    random_phase(50);
    load_setting(8'd0, 6'd1, 6'd2, 6'd3, 6'd1);
    random_phase(40);
    load_setting(8'd0, 6'd0, 6'd0, 6'd0, 6'd0);
    random_phase(20);
    load_setting(8'd3, 6'd1, 6'd1, 6'd2, 6'd5);
    random_phase(40);
    load_setting(8'd2, 6'd3, 6'd5, 6'd6, 6'd4);
    random_phase(40);
    load_setting(8'd1, 6'd1, 6'd63, 6'd2, 6'd2);
    random_phase(40);
    load_setting(8'd1, 6'd63, 6'd1, 6'd1, 6'd1);
    random_phase(40);

    wait_quiet();
    if (errors == 0)
      $display("tag_access_controller test passed");
    else
      $display("tag_access_controller test failed");
    $finish;
  end

  initial begin
    #20000000;
    $display("tag_access_controller test failed");
    $finish;
  end

endmodule
